// ===== src/ieqd_pkg.sv =====
`timescale 1ns / 1ps
package ieqd_pkg;

	// item kinds, carried on s_tuser
	typedef enum logic [2:0] {
		MODE_KEY    = 3'd0,
		MODE_MOTION = 3'd1,
		MODE_BUTTON = 3'd2,
		MODE_WHEEL  = 3'd3,
		MODE_BATCH  = 3'd4,
		MODE_DRAIN  = 3'd5,
		MODE_CFG_WR = 3'd6,
		MODE_CFG_RD = 3'd7
	} mode_t;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EMPTY  = 3'd1;
	localparam logic [2:0] ST_NODESC = 3'd2;
	localparam logic [2:0] ST_FAULT  = 3'd3;
	localparam logic [2:0] ST_DROP   = 3'd4;

	localparam logic [1:0] TYPE_SYN = 2'd0;
	localparam logic [1:0] TYPE_KEY = 2'd1;
	localparam logic [1:0] TYPE_REL = 2'd2;

	localparam logic [8:0] CODE_REL_X        = 9'd0;
	localparam logic [8:0] CODE_REL_Y        = 9'd1;
	localparam logic [8:0] CODE_REL_HWHEEL   = 9'd6;
	localparam logic [8:0] CODE_REL_WHEEL    = 9'd8;
	localparam logic [8:0] CODE_MOUSE_LEFT   = 9'h110;
	localparam logic [8:0] CODE_MOUSE_RIGHT  = 9'h111;
	localparam logic [8:0] CODE_MOUSE_MIDDLE = 9'h112;

	localparam logic [1:0] BUTTON_ID_LEFT   = 2'd1;
	localparam logic [1:0] BUTTON_ID_MIDDLE = 2'd2;
	localparam logic [1:0] BUTTON_ID_RIGHT  = 2'd3;

	// config space
	localparam logic [7:0] CFG_ADDR_SELECT = 8'd0;
	localparam logic [7:0] CFG_ADDR_SUBSEL = 8'd1;
	localparam logic [7:0] CFG_ADDR_SIZE   = 8'd2;
	localparam logic [7:0] CFG_ADDR_DATA   = 8'd8;
	localparam logic [7:0] SEL_ID_NAME     = 8'h01;
	localparam logic [7:0] SEL_ID_SERIAL   = 8'h02;
	localparam logic [7:0] SEL_ID_DEVIDS   = 8'h10;
	localparam logic [7:0] SEL_EV_BITS     = 8'h11;
	localparam logic [7:0] EV_BITS_SIZE    = 8'd128;
	localparam logic [7:0] EV_BITS_BYTE    = 8'hff;

	// ring record: {type, code, value}
	localparam int REC_W = 43;

	localparam int ID_TEXT_LEN = 25;
	localparam logic [8*ID_TEXT_LEN-1:0] ID_TEXT = "input-event-queue-device ";

	// offset modulo the text length by conditional subtraction (offsets stay below 256)
	function automatic logic [7:0] id_byte(input logic [7:0] off);
		logic [7:0] idx;
		idx = off;
		if (idx >= 8'(8 * ID_TEXT_LEN)) idx = idx - 8'(8 * ID_TEXT_LEN);
		if (idx >= 8'(4 * ID_TEXT_LEN)) idx = idx - 8'(4 * ID_TEXT_LEN);
		if (idx >= 8'(2 * ID_TEXT_LEN)) idx = idx - 8'(2 * ID_TEXT_LEN);
		if (idx >= 8'(ID_TEXT_LEN)) idx = idx - 8'(ID_TEXT_LEN);
		return ID_TEXT[8*(ID_TEXT_LEN-1-int'(idx)) +: 8];
	endfunction

	typedef struct packed {
		logic load_item;
		logic exec_first;
		logic exec_second;
		logic capture;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic two_step;
		logic pop;
		logic out_free;
	} sts_t;

endpackage

// ===== src/ieqd_ram.sv =====
`timescale 1ns / 1ps
module ieqd_ram #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ieqd_ctrl.sv =====
`timescale 1ns / 1ps
module ieqd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  ieqd_pkg::sts_t  sts,
	output ieqd_pkg::cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_FIRST  = 5'b00010,
		S_SECOND = 5'b00100,
		S_FETCH  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_FIRST;
			end
			S_FIRST: begin
				if (sts.two_step) state_d = S_SECOND;
				else if (sts.pop) state_d = S_FETCH;
				else state_d = S_DONE;
			end
			S_SECOND: state_d = S_DONE;
			S_FETCH:  state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready        = (state_q == S_IDLE);
	assign cmd.load_item   = (state_q == S_IDLE) && s_tvalid;
	assign cmd.exec_first  = (state_q == S_FIRST);
	assign cmd.exec_second = (state_q == S_SECOND);
	assign cmd.capture     = (state_q == S_FETCH);
	assign cmd.load_out    = (state_q == S_DONE) && sts.out_free;

endmodule

// ===== src/ieqd_dp.sv =====
`timescale 1ns / 1ps
module ieqd_dp #(
	parameter int DEPTH  = 128,
	parameter int ID_LEN = 27
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     s_tuser,
	input  logic [95:0]    s_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [3:0]     m_tuser,
	output logic [71:0]    m_tdata,
	input  ieqd_pkg::cmd_t cmd,
	output ieqd_pkg::sts_t sts
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [7:0] ID_SIZE = 8'(ID_LEN);

	// captured item
	ieqd_pkg::mode_t    mode_q;
	logic [8:0]         key_code_q;
	logic               pressed_q;
	logic               repeat_req_q;
	logic signed [31:0] delta_first_q;
	logic signed [31:0] delta_second_q;
	logic [1:0]         button_id_q;
	logic               desc_ok_q;
	logic [7:0]         cfg_addr_q;
	logic [7:0]         cfg_wdata_q;

	// ring and config state
	logic [AW-1:0] read_idx_q, write_idx_q;
	logic [CW-1:0] fill_q;
	logic          sync_pending_q;
	logic [7:0]    cfg_select_q, cfg_subselect_q;

	// result being built, and output register
	logic [2:0]  res_status_q;
	logic        res_valid_q;
	logic [1:0]  res_type_q;
	logic [8:0]  res_code_q;
	logic [31:0] res_value_q;
	logic [7:0]  res_rdata_q;
	logic        m_tvalid_q;
	logic [2:0]  out_status_q;
	logic        out_valid_q;
	logic [1:0]  out_type_q;
	logic [8:0]  out_code_q;
	logic [31:0] out_value_q;
	logic [7:0]  out_rdata_q;

	logic        rec_want, rec_sync;
	logic [1:0]  rec_type;
	logic [8:0]  rec_code;
	logic [31:0] rec_value;
	logic        exec, full, push, drop, pop;
	logic [ieqd_pkg::REC_W-1:0] ram_rdata;
	logic [7:0]  cfg_size, cfg_off, rd_byte;
	logic        ev_bits_on, rd_fault;
	logic [2:0]  first_status;

	// record to append in this step
	always_comb begin
		rec_want  = 1'b0;
		rec_sync  = 1'b0;
		rec_type  = ieqd_pkg::TYPE_REL;
		rec_code  = ieqd_pkg::CODE_REL_X;
		rec_value = '0;
		if (cmd.exec_second) begin
			case (mode_q)
				ieqd_pkg::MODE_MOTION: begin
					rec_want  = (delta_second_q != 0);
					rec_code  = ieqd_pkg::CODE_REL_Y;
					rec_value = delta_second_q;
				end
				ieqd_pkg::MODE_WHEEL: begin
					rec_want  = (delta_second_q != 0);
					rec_code  = ieqd_pkg::CODE_REL_HWHEEL;
					rec_value = delta_second_q;
				end
				default: rec_want = 1'b0;
			endcase
		end else begin
			case (mode_q)
				ieqd_pkg::MODE_KEY: begin
					rec_want  = (key_code_q != '0);
					rec_type  = ieqd_pkg::TYPE_KEY;
					rec_code  = key_code_q;
					rec_value = repeat_req_q ? 32'd2 : {31'd0, pressed_q};
				end
				ieqd_pkg::MODE_MOTION: begin
					rec_want  = (delta_first_q != 0);
					rec_code  = ieqd_pkg::CODE_REL_X;
					rec_value = delta_first_q;
				end
				ieqd_pkg::MODE_BUTTON: begin
					rec_want  = (button_id_q != '0);
					rec_type  = ieqd_pkg::TYPE_KEY;
					rec_value = {31'd0, pressed_q};
					case (button_id_q)
						ieqd_pkg::BUTTON_ID_LEFT:   rec_code = ieqd_pkg::CODE_MOUSE_LEFT;
						ieqd_pkg::BUTTON_ID_MIDDLE: rec_code = ieqd_pkg::CODE_MOUSE_MIDDLE;
						ieqd_pkg::BUTTON_ID_RIGHT:  rec_code = ieqd_pkg::CODE_MOUSE_RIGHT;
						default:                    rec_code = ieqd_pkg::CODE_REL_X;
					endcase
				end
				ieqd_pkg::MODE_WHEEL: begin
					rec_want  = (delta_first_q != 0);
					rec_code  = ieqd_pkg::CODE_REL_WHEEL;
					rec_value = delta_first_q;
				end
				ieqd_pkg::MODE_BATCH: begin
					rec_want = sync_pending_q;
					rec_sync = 1'b1;
					rec_type = ieqd_pkg::TYPE_SYN;
				end
				default: rec_want = 1'b0;
			endcase
		end
	end

	assign exec = cmd.exec_first || cmd.exec_second;
	assign full = (fill_q == CW'(DEPTH));
	assign push = exec && rec_want && !full;
	assign drop = exec && rec_want && full;
	assign pop  = cmd.exec_first && (mode_q == ieqd_pkg::MODE_DRAIN)
		&& (fill_q != '0) && desc_ok_q;

	// config space read
	assign ev_bits_on = (cfg_subselect_q == 8'(ieqd_pkg::TYPE_KEY))
		|| (cfg_subselect_q == 8'(ieqd_pkg::TYPE_REL));
	assign cfg_off = cfg_addr_q - ieqd_pkg::CFG_ADDR_DATA;

	always_comb begin
		case (cfg_select_q)
			ieqd_pkg::SEL_ID_NAME, ieqd_pkg::SEL_ID_SERIAL: cfg_size = ID_SIZE;
			ieqd_pkg::SEL_ID_DEVIDS: cfg_size = 8'd1;
			ieqd_pkg::SEL_EV_BITS:   cfg_size = ev_bits_on ? ieqd_pkg::EV_BITS_SIZE : 8'd0;
			default:                 cfg_size = 8'd0;
		endcase
	end

	always_comb begin
		rd_byte  = 8'd0;
		rd_fault = 1'b0;
		if (cfg_addr_q == ieqd_pkg::CFG_ADDR_SELECT) begin
			rd_byte = cfg_select_q;
		end else if (cfg_addr_q == ieqd_pkg::CFG_ADDR_SUBSEL) begin
			rd_byte = cfg_subselect_q;
		end else if (cfg_addr_q == ieqd_pkg::CFG_ADDR_SIZE) begin
			rd_byte = cfg_size;
		end else if (cfg_addr_q >= ieqd_pkg::CFG_ADDR_DATA && cfg_off < cfg_size) begin
			case (cfg_select_q)
				ieqd_pkg::SEL_ID_NAME, ieqd_pkg::SEL_ID_SERIAL:
					rd_byte = ieqd_pkg::id_byte(cfg_off);
				ieqd_pkg::SEL_EV_BITS: rd_byte = ev_bits_on ? ieqd_pkg::EV_BITS_BYTE : 8'd0;
				default:               rd_byte = 8'd0;
			endcase
		end else begin
			rd_fault = 1'b1;
		end
	end

	always_comb begin
		first_status = ieqd_pkg::ST_OK;
		case (mode_q)
			ieqd_pkg::MODE_DRAIN: begin
				if (fill_q == '0) first_status = ieqd_pkg::ST_EMPTY;
				else if (!desc_ok_q) first_status = ieqd_pkg::ST_NODESC;
			end
			ieqd_pkg::MODE_CFG_WR: begin
				if (cfg_addr_q != ieqd_pkg::CFG_ADDR_SELECT
					&& cfg_addr_q != ieqd_pkg::CFG_ADDR_SUBSEL)
					first_status = ieqd_pkg::ST_FAULT;
			end
			ieqd_pkg::MODE_CFG_RD: begin
				if (rd_fault) first_status = ieqd_pkg::ST_FAULT;
			end
			default: first_status = ieqd_pkg::ST_OK;
		endcase
		if (drop) first_status = ieqd_pkg::ST_DROP;
	end

	ieqd_ram #(
		.WIDTH(ieqd_pkg::REC_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (push),
		.waddr (write_idx_q),
		.wdata ({rec_type, rec_code, rec_value}),
		.re    (pop),
		.raddr (read_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_idx_q      <= '0;
			write_idx_q     <= '0;
			fill_q          <= '0;
			sync_pending_q  <= 1'b0;
			cfg_select_q    <= '0;
			cfg_subselect_q <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (push) begin
				write_idx_q <= (write_idx_q == AW'(DEPTH - 1)) ? '0 : write_idx_q + AW'(1);
			end
			if (pop) begin
				read_idx_q <= (read_idx_q == AW'(DEPTH - 1)) ? '0 : read_idx_q + AW'(1);
			end
			if (push) fill_q <= fill_q + CW'(1);
			else if (pop) fill_q <= fill_q - CW'(1);
			if (push && !rec_sync) begin
				sync_pending_q <= 1'b1;
			end else if (cmd.exec_first && mode_q == ieqd_pkg::MODE_BATCH) begin
				sync_pending_q <= 1'b0;
			end
			if (cmd.exec_first && mode_q == ieqd_pkg::MODE_CFG_WR) begin
				if (cfg_addr_q == ieqd_pkg::CFG_ADDR_SELECT) cfg_select_q <= cfg_wdata_q;
				else if (cfg_addr_q == ieqd_pkg::CFG_ADDR_SUBSEL) cfg_subselect_q <= cfg_wdata_q;
			end
			if (cmd.load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q         <= ieqd_pkg::mode_t'(s_tuser);
			key_code_q     <= s_tdata[8:0];
			pressed_q      <= s_tdata[9];
			repeat_req_q   <= s_tdata[10];
			delta_first_q  <= s_tdata[42:11];
			delta_second_q <= s_tdata[74:43];
			button_id_q    <= s_tdata[76:75];
			desc_ok_q      <= s_tdata[77];
			cfg_addr_q     <= s_tdata[85:78];
			cfg_wdata_q    <= s_tdata[93:86];
		end
		if (cmd.exec_first) begin
			res_status_q <= first_status;
			res_valid_q  <= pop;
			res_type_q   <= '0;
			res_code_q   <= '0;
			res_value_q  <= '0;
			res_rdata_q  <= (mode_q == ieqd_pkg::MODE_CFG_RD) ? rd_byte : 8'd0;
		end
		if (cmd.exec_second && drop) begin
			res_status_q <= ieqd_pkg::ST_DROP;
		end
		if (cmd.capture) begin
			{res_type_q, res_code_q, res_value_q} <= ram_rdata;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_valid_q  <= res_valid_q;
			out_type_q   <= res_type_q;
			out_code_q   <= res_code_q;
			out_value_q  <= res_value_q;
			out_rdata_q  <= res_rdata_q;
		end
	end

	assign sts.two_step = (mode_q == ieqd_pkg::MODE_MOTION) || (mode_q == ieqd_pkg::MODE_WHEEL);
	assign sts.pop      = pop;
	assign sts.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {out_valid_q, out_status_q};
	assign m_tdata  = {out_rdata_q, out_value_q, 7'd0, out_code_q, 14'd0, out_type_q};

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("ring fill count above depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> fill_q != CW'(DEPTH))
		else $error("ring write while full");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fill_q != '0 && !push)
		else $error("ring read while empty or during a write");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid_q)
		else $error("result load did not raise m_tvalid");
`endif

endmodule

// ===== src/input_event_queue_device_unit.sv =====
`timescale 1ns / 1ps
// Input-event queue: host key/motion/button/wheel events in, evdev records out
// through a ring, plus a byte-wide config space.
// Slave stream: s_tuser carries the item kind, s_tdata the item fields.
// Every accepted item gives exactly one transfer on the master stream:
// status and event_valid on m_tuser, the drained record and config read byte
// on m_tdata (all zero where unused).
// Timing: the item is registered, worked in S_FIRST and held in S_DONE until
// the output register is free; m_tvalid rises and s_tready comes back at the
// same time, so no new item is taken before this result is loaded. Motion,
// wheel and a drain that delivers a record pass one more state, for the second
// ring write (the ring RAM has one write port) or the registered RAM read.
// The result waits in an output register; while it is not taken the block
// still accepts and works on the next item and stalls only when that next
// result is ready to load.
// Reset clears the ring pointers, fill count, sync flag and select/subselect;
// the ring storage itself is not cleared, and no entry is read before it is
// written. When the ring is full new records are dropped with status 4.
module input_event_queue_device_unit #(
	parameter int DEPTH  = 128,
	parameter int ID_LEN = 27
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // mode
	input  logic [95:0] s_tdata,  // key_code, pressed, repeat_req, delta_first,
	                              // delta_second, button_id, desc_ok, cfg_addr,
	                              // cfg_wdata, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [3:0]  m_tuser,  // status, event_valid
	output logic [71:0] m_tdata   // event_type, event_code, event_value, read_data
);

	ieqd_pkg::cmd_t cmd;
	ieqd_pkg::sts_t sts;

	ieqd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ieqd_dp #(
		.DEPTH  (DEPTH),
		.ID_LEN (ID_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
